@@ rtl/efws_pkg.sv @@
// ---------------------------------------------------------------------------
// efws_pkg
// shared widths and the result bundle of the earliest free worker scheduler
// ---------------------------------------------------------------------------
package efws_pkg;

  localparam int TIME_W   = 48;
  localparam int DUR_W    = 32;
  localparam int WORKER_W = 4;
  localparam int CFG_W    = 5;

  typedef logic [TIME_W-1:0] time_t;

  typedef struct packed {
    logic                valid;
    logic [WORKER_W-1:0] worker;
    time_t               job_start;
  } efws_res_t;

endpackage

@@ rtl/efws_mem.sv @@
// ---------------------------------------------------------------------------
// efws_mem
// busy-until time store, one write port and one read port, registered read
// ---------------------------------------------------------------------------
module efws_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  efws_pkg::time_t       wdata,
  input  logic [AW-1:0]         raddr,
  output efws_pkg::time_t       rdata
);
  import efws_pkg::*;

  time_t mem_r [DEPTH];
  time_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/efws_ctrl.sv @@
// ---------------------------------------------------------------------------
// efws_ctrl
// request sequencer: scans the busy-until store for the earliest worker,
// updates its time and clears the store on reset and on a batch start
// ---------------------------------------------------------------------------
module efws_ctrl #(
  parameter int MAX_WORKERS = 16,
  parameter int IW          = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [efws_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [efws_pkg::DUR_W-1:0]    in_duration,
  input  logic                          in_batch_start,
  input  logic                          out_ready,
  output efws_pkg::efws_res_t           res,
  output logic                          mem_we,
  output logic [IW-1:0]                 mem_waddr,
  output efws_pkg::time_t               mem_wdata,
  output logic [IW-1:0]                 mem_raddr,
  input  efws_pkg::time_t               mem_rdata
);
  import efws_pkg::*;

  localparam int CW = $clog2(MAX_WORKERS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_WORKERS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLR,
    S_SCAN,
    S_WB
  } state_t;

  state_t             state_r;
  logic [CFG_W-1:0]   act_r;
  logic [CW-1:0]      n_w;
  logic [CW-1:0]      k_r;
  logic [IW-1:0]      pend_idx_r;
  logic [IW-1:0]      clr_idx_r;
  logic               clr_job_r;
  logic [IW-1:0]      best_idx_r;
  time_t              best_time_r;
  logic [DUR_W-1:0]   dur_r;
  logic [TIME_W:0]    sum_w;
  time_t              upd_w;
  logic               take_w;
  logic               accept_w;

  // active worker count, clamped to one .. MAX_WORKERS
  always_comb begin
    if (act_r == '0) begin
      n_w = CW'(1);
    end else if (32'(act_r) > MAX_WORKERS) begin
      n_w = CW'(MAX_WORKERS);
    end else begin
      n_w = CW'(act_r);
    end
  end

  assign accept_w = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || !rst_n;

  // saturating update of the chosen worker
  assign sum_w = {1'b0, best_time_r} + (TIME_W + 1)'(dur_r);
  assign upd_w = sum_w[TIME_W] ? {TIME_W{1'b1}} : sum_w[TIME_W-1:0];

  assign take_w = (pend_idx_r == '0) || (mem_rdata < best_time_r);

  always_comb begin
    mem_raddr = '0;
    if (state_r == S_SCAN) begin
      mem_raddr = k_r[IW-1:0];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_idx_r;
    mem_wdata = upd_w;
    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '0;
      end
      S_WB: begin
        mem_we = out_ready;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign res.valid     = (state_r == S_WB) && out_ready;
  assign res.worker    = WORKER_W'(best_idx_r);
  assign res.job_start = best_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      act_r     <= CFG_W'(1);
      clr_idx_r <= '0;
      clr_job_r <= 1'b0;
      k_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        act_r <= cfg_wr_data;
      end
      case (state_r)
        S_IDLE: begin
          if (accept_w) begin
            dur_r      <= in_duration;
            pend_idx_r <= '0;
            clr_idx_r  <= '0;
            clr_job_r  <= 1'b1;
            if (in_batch_start) begin
              state_r <= S_CLR;
            end else begin
              // address zero is read during the accept cycle
              k_r     <= CW'(1);
              state_r <= S_SCAN;
            end
          end
        end
        S_CLR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == LAST_IDX) begin
            best_idx_r  <= '0;
            best_time_r <= '0;
            state_r     <= clr_job_r ? S_WB : S_IDLE;
          end
        end
        S_SCAN: begin
          if (take_w) begin
            best_idx_r  <= pend_idx_r;
            best_time_r <= mem_rdata;
          end
          if (k_r < n_w) begin
            pend_idx_r <= k_r[IW-1:0];
            k_r        <= k_r + 1'b1;
          end else begin
            state_r <= S_WB;
          end
        end
        S_WB: begin
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    accept_w |=> (state_r == S_SCAN || state_r == S_CLR))
    else $error("accepted request did not start a scan or clear");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CW'(pend_idx_r) < n_w))
    else $error("scan read beyond the active workers");

  a_choice_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |-> (CW'(best_idx_r) < n_w))
    else $error("chosen worker not active");

  a_result_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> (state_r == S_IDLE))
    else $error("sequencer busy after result");
`endif

endmodule

@@ rtl/earliest_free_worker_scheduler_top.sv @@
// ---------------------------------------------------------------------------
// earliest_free_worker_scheduler_top
// assigns each job to the active worker that frees up first and returns the
// worker with the job's start time
// ---------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------------
//  in       | in_valid / in_stall         | in_duration, in_batch_start
//  out      | out_valid / out_stall       | out_worker, out_job_start
//  cfg      | cfg_wr_en                   | cfg_wr_data (active_workers)
//
//  out_valid rises after a request is accepted, once the one-read-per-cycle
//  scan of the time store has covered n, the clamped active worker count;
//  a new request waits until the last result is in the output register
//  a batch-start request skips the scan and runs a clearing sweep over all
//  MAX_WORKERS entries; its result is worker zero with start time zero
//  after reset a clearing pass runs with in_stall high
//  the next request is taken while a result waits in the output register
// ---------------------------------------------------------------------------
module earliest_free_worker_scheduler_top #(
  parameter int MAX_WORKERS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [efws_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [efws_pkg::DUR_W-1:0]         in_duration,
  input  logic                               in_batch_start,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [efws_pkg::WORKER_W-1:0]      out_worker,
  output logic [efws_pkg::TIME_W-1:0]        out_job_start
);
  import efws_pkg::*;

  localparam int IW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

  efws_res_t           res;
  logic                out_ready;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  time_t               mem_wdata;
  logic [IW-1:0]       mem_raddr;
  time_t               mem_rdata;
  logic                out_valid_r;
  logic [WORKER_W-1:0] out_worker_r;
  time_t               out_start_r;

  assign out_ready = !out_valid_r || !out_stall;

  efws_ctrl #(
    .MAX_WORKERS (MAX_WORKERS),
    .IW          (IW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_duration    (in_duration),
    .in_batch_start (in_batch_start),
    .out_ready      (out_ready),
    .res            (res),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  efws_mem #(
    .DEPTH (MAX_WORKERS),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_worker_r <= res.worker;
      out_start_r  <= res.job_start;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_worker    = out_worker_r;
  assign out_job_start = out_start_r;

endmodule
